// ===== hw/rtl/aod_pkg.sv =====
package aod_pkg;

	localparam int unsigned WORD_W          = 32;
	localparam int unsigned VERSION_W       = 8;
	localparam int unsigned CFG_INDEX_W     = 1;
	localparam int unsigned CFG_DATA_W      = 32;
	localparam int unsigned QUEUE_DEPTH_DEF = 2;
	localparam int unsigned CANDIDATE_COUNT = 255;
	localparam int unsigned VERSION_COUNT   = 1 << VERSION_W;
	localparam logic [WORD_W-1:0] OFFSET_BIAS = 32'h581C_3F6D;
	localparam logic [WORD_W-1:0] DIGIT_BASE  = 32'h0000_0031; // ASCII '0' plus one

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_VERSION_BYTE = 1'b0,
		REG_DATA_START   = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic              found;
		logic [WORD_W-1:0] key;
	} key_ent_t;

	typedef key_ent_t [VERSION_COUNT-1:0] key_tab_t;

	// Shared by front and back; user keeps them constant while words are in flight.
	typedef struct packed {
		logic              found;
		logic [WORD_W-1:0] key;
		logic [WORD_W-1:0] start;
	} cfg_t;

	// One classified word on its way from front to back.
	typedef struct packed {
		logic [WORD_W-1:0] diff;
		logic [WORD_W-1:0] word;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Fold decimal digits into the candidate sum, most significant digit first.
	function automatic logic [WORD_W-1:0] fold_digit(logic [WORD_W-1:0] sum, int unsigned d);
		logic [WORD_W-1:0] r;
		r = (sum << 5) + DIGIT_BASE + WORD_W'(d);
		return r;
	endfunction

	// Version byte to key map. Walk candidates from high to low so that the
	// lowest matching candidate is the one left in each entry.
	function automatic key_tab_t build_key_table();
		key_tab_t          tab;
		logic [WORD_W-1:0] s;
		logic [7:0]        x;
		int unsigned       i;
		tab = '0;
		for (int h = 2; h >= 0; h--) begin
			for (int t = 9; t >= 0; t--) begin
				for (int u = 9; u >= 0; u--) begin
					i = 100 * h + 10 * t + u;
					if (i < CANDIDATE_COUNT) begin
						s = '0;
						if (h > 0) begin
							s = fold_digit(s, h);
							s = fold_digit(s, t);
						end else if (t > 0) begin
							s = fold_digit(s, t);
						end
						s = fold_digit(s, u);
						x = ~(s[31:24] ^ s[23:16] ^ s[15:8] ^ s[7:0]);
						tab[x] = '{found: 1'b1, key: s};
					end
				end
			end
		end
		return tab;
	endfunction

	localparam key_tab_t KEY_TABLE = build_key_table();

endpackage

// ===== hw/rtl/aod_front.sv =====
module aod_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [aod_pkg::WORD_W-1:0]       word_position,
	input  logic [aod_pkg::WORD_W-1:0]       scrambled_word,
	input  logic                             cfg_we,
	input  logic [aod_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [aod_pkg::CFG_DATA_W-1:0]   cfg_data,
	output aod_pkg::cfg_t                    cfg,
	output logic                             push,
	output aod_pkg::item_t                   push_item,
	input  aod_pkg::q_stat_t                 q_stat
);
	import aod_pkg::*;

	key_ent_t          key_q;
	logic [WORD_W-1:0] start_q;
	logic              v_s1;
	item_t             item_s1;

	// Settings: key comes straight from the table on a version write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q   <= KEY_TABLE[VERSION_W'(0)];
			start_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_VERSION_BYTE: key_q   <= KEY_TABLE[cfg_data[VERSION_W-1:0]];
				REG_DATA_START:   start_q <= cfg_data[WORD_W-1:0];
				default: ;
			endcase
		end
	end

	assign push     = v_s1 && !q_stat.full;
	assign in_ready = !v_s1 || !q_stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.diff <= ~(word_position - start_q);
			item_s1.word <= scrambled_word;
		end
	end

	assign push_item = item_s1;
	assign cfg       = '{found: key_q.found, key: key_q.key, start: start_q};

endmodule

// ===== hw/rtl/aod_queue.sv =====
module aod_queue #(
	parameter int unsigned DEPTH = aod_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  aod_pkg::item_t   push_item,
	input  logic             pop,
	output aod_pkg::item_t   head,
	output aod_pkg::q_stat_t q_stat
);
	import aod_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	item_t             mem [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

	assign head         = mem[rd_ptr_q];
	assign q_stat.full  = (count_q == CNT_W'(DEPTH));
	assign q_stat.empty = (count_q == '0);

endmodule

// ===== hw/rtl/aod_back.sv =====
module aod_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  aod_pkg::cfg_t               cfg,
	input  aod_pkg::item_t              head,
	input  aod_pkg::q_stat_t            q_stat,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [aod_pkg::WORD_W-1:0]  plain_offset,
	output logic                        key_found
);
	import aod_pkg::*;

	logic              v_s2, v_s3, v_s4;
	logic              rdy_s2, rdy_s3, rdy_s4;
	logic [WORD_W-1:0] prod_s2, word_s2;
	logic [WORD_W-1:0] t_s3, word_s3;
	logic [WORD_W-1:0] off_s4;
	logic [2*WORD_W-1:0] rot_wide;
	logic [WORD_W-1:0] rot;

	assign rdy_s4 = !v_s4 || out_ready;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign pop    = !q_stat.empty && rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s2) v_s2 <= !q_stat.empty;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	assign rot_wide = {t_s3, t_s3} << t_s3[4:0];
	assign rot      = rot_wide[2*WORD_W-1:WORD_W];

	always_ff @(posedge clk) begin
		if (pop) begin
			prod_s2 <= WORD_W'(head.diff * cfg.key);
			word_s2 <= head.word;
		end
		if (v_s2 && rdy_s3) begin
			t_s3    <= prod_s2 - OFFSET_BIAS;
			word_s3 <= word_s2;
		end
		if (v_s3 && rdy_s4) begin
			off_s4 <= (rot ^ word_s3) + cfg.start;
		end
	end

	assign out_valid    = v_s4;
	assign plain_offset = off_s4;
	assign key_found    = cfg.found;

endmodule

// ===== hw/rtl/archive_offset_descrambler_core.sv =====
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_ready   | word_position, scrambled_word
// out     | output    | out_valid / out_ready | plain_offset, key_found
// cfg     | input     | cfg_we (no wait)      | cfg_index, cfg_data
//
// One word per cycle sustained while the output is not stalled; an accepted
// word passes the front register (loaded at acceptance), then the queue,
// multiply, bias and output registers before out_valid rises.
// Reset is asynchronous; the key for version byte zero is loaded at reset.
// Either side may stall alone: with the output held, in_ready drops once
// QUEUE_DEPTH plus four words are held (queue, three back stages, front).
module archive_offset_descrambler_core #(
	parameter int unsigned QUEUE_DEPTH = aod_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [aod_pkg::WORD_W-1:0]      word_position,
	input  logic [aod_pkg::WORD_W-1:0]      scrambled_word,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [aod_pkg::WORD_W-1:0]      plain_offset,
	output logic                            key_found,
	input  logic                            cfg_we,
	input  logic [aod_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [aod_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import aod_pkg::*;

	cfg_t    cfg;
	item_t   push_item;
	item_t   head;
	q_stat_t q_stat;
	logic    push;
	logic    pop;

	// Front: hold settings, look up the key, and form ~(position - start).
	aod_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.word_position  (word_position),
		.scrambled_word (scrambled_word),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cfg            (cfg),
		.push           (push),
		.push_item      (push_item),
		.q_stat         (q_stat)
	);

	// Decouple the two halves so a stalled output does not freeze the front.
	aod_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	// Back: multiply by the key, drop the bias, rotate, unmask and rebase.
	aod_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.head         (head),
		.q_stat       (q_stat),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.plain_offset (plain_offset),
		.key_found    (key_found)
	);

endmodule

// ===== hw/rtl/aod_checker.sv =====
module aod_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [aod_pkg::WORD_W-1:0]      plain_offset,
	input logic                            key_found
);
	import aod_pkg::*;

	// A word offered on the output stays until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("out_valid dropped before the word was taken");

	// Leaving reset the pipeline is empty and the front is open.
	a_reset_state: assert property (@(posedge clk)
		(arst_n && !$past(arst_n)) |-> (!out_valid && in_ready))
		else $error("pipeline not empty after reset");

	// A stalled output word keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> ($stable(plain_offset) && $stable(key_found)))
		else $error("output payload changed while stalled");

endmodule

bind archive_offset_descrambler_core aod_checker u_aod_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.plain_offset (plain_offset),
	.key_found    (key_found)
);

// ===== tb/archive_offset_descrambler_core_test.sv =====
module archive_offset_descrambler_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import aod_pkg::*;

	// Scrambling bias subtracted from the keyed product before the rotate.
	localparam logic [31:0] SCRAMBLE_BIAS = 32'h581C_3F6D;
	// Decimal candidates tried when looking up the version key.
	localparam int unsigned KEY_CANDIDATES = 255;
	// Cycles to let pass once the last expected word is back, before touching
	// the registers or ending the run.
	localparam int unsigned SETTLE_CYCLES = 10;
	localparam time RUN_LIMIT = 5ms;

	typedef struct {
		logic        found;
		logic [31:0] key;
	} version_key_t;

	typedef struct {
		logic [31:0] offset;
		logic        found;
	} offset_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] word_position;
	logic [31:0] scrambled_word;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] plain_offset;
	logic        key_found;
	logic        cfg_we;
	cfg_reg_t    cfg_index;
	logic [31:0] cfg_data;

	// Shadow of the configuration as the block should see it.
	logic [7:0]   shadow_version;
	logic [31:0]  shadow_start;
	version_key_t shadow_key;

	// Descrambled offsets still owed by the block, oldest first.
	offset_result_t pending_offsets[$];

	int unsigned mismatch_count;
	int unsigned src_idle_pct;
	int unsigned sink_stall_pct;

	archive_offset_descrambler_core DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.word_position  (word_position),
		.scrambled_word (scrambled_word),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.plain_offset   (plain_offset),
		.key_found      (key_found),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop in case the pipeline hangs.
	initial begin
		#RUN_LIMIT;
		$display("archive_offset_descrambler_core_test: errors");
		$finish;
	end

	// Fold the decimal digits of a candidate, most significant first, into
	// sum = sum*32 + (ASCII digit + 1).
	function automatic logic [31:0] candidate_sum(int unsigned n);
		int unsigned digit[3];
		int unsigned count;
		logic [31:0] sum;
		digit[0] = n / 100;
		digit[1] = (n / 10) % 10;
		digit[2] = n % 10;
		count = (n >= 100) ? 3 : (n >= 10) ? 2 : 1;
		sum = '0;
		for (int k = 3 - count; k < 3; k++)
			sum = (sum << 5) + 32'h31 + 32'(digit[k]);
		return sum;
	endfunction

	// Version byte that a candidate's sum stands for: inverted XOR of its bytes.
	function automatic logic [7:0] version_of(int unsigned n);
		logic [31:0] s;
		s = candidate_sum(n);
		return ~(s[31:24] ^ s[23:16] ^ s[15:8] ^ s[7:0]);
	endfunction

	// First candidate whose version byte matches wins; none leaves a zero key.
	function automatic version_key_t lookup_key(logic [7:0] v);
		version_key_t r;
		r.found = 1'b0;
		r.key = '0;
		for (int unsigned n = 0; n < KEY_CANDIDATES; n++) begin
			if (version_of(n) == v) begin
				r.found = 1'b1;
				r.key = candidate_sum(n);
				return r;
			end
		end
		return r;
	endfunction

	// Keyed value before the rotate.
	function automatic logic [31:0] keyed_mix(logic [31:0] pos);
		return (~(pos - shadow_start)) * shadow_key.key - SCRAMBLE_BIAS;
	endfunction

	function automatic offset_result_t descramble(logic [31:0] pos, logic [31:0] word);
		offset_result_t r;
		logic [31:0] t;
		logic [63:0] spun;
		t = keyed_mix(pos);
		// Rotate left by the low five bits; an amount of zero leaves t as is.
		spun = {t, t} << t[4:0];
		r.offset = (spun[63:32] ^ word) + shadow_start;
		r.found = shadow_key.found;
		return r;
	endfunction

	// Compare every accepted output word with the oldest prediction.
	always @(posedge clk) begin : check_offsets
		offset_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_offsets.size() == 0) begin
				$display("%0t: unexpected word plain_offset %h key_found %b",
					$time, plain_offset, key_found);
				mismatch_count++;
			end else begin
				want = pending_offsets.pop_front();
				if (plain_offset !== want.offset) begin
					$display("%0t: plain_offset expected %h got %h",
						$time, want.offset, plain_offset);
					mismatch_count++;
				end
				if (key_found !== want.found) begin
					$display("%0t: key_found expected %b got %b",
						$time, want.found, key_found);
					mismatch_count++;
				end
			end
		end
	end

	// Receiver: stall at the rate of the current phase.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
		end
	end

	// Offer one word, hold it until taken, and log what it must turn into.
	// Enter and leave on a falling edge.
	task automatic send_word(logic [31:0] pos, logic [31:0] word);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		word_position <= pos;
		scrambled_word <= word;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_offsets.push_back(descramble(pos, word));
		@(negedge clk);
	endtask

	// Drop valid, wait for every owed word, then let the pipeline go quiet.
	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (pending_offsets.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Registers change only with the pipeline empty.
	task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		if (idx == REG_VERSION_BYTE) begin
			shadow_version = value[7:0];
			shadow_key = lookup_key(shadow_version);
		end else begin
			shadow_start = value;
		end
	endtask

	task automatic configure(logic [7:0] version, logic [31:0] start);
		drain_pipeline();
		// Upper data bits are junk for the version register; the block keeps
		// only the low byte.
		write_reg(REG_VERSION_BYTE, {24'($urandom), version});
		write_reg(REG_DATA_START, start);
	endtask

	// Defaults after reset: version zero, data start zero.
	task automatic test_reset_defaults();
		send_word(32'h0000_0000, 32'h0000_0000);
		send_word(32'h0000_1000, 32'hDEAD_BEEF);
		send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
	endtask

	// Field extremes with real keys (candidate zero, version 0xCE, then the last candidate).
	task automatic test_field_extremes();
		configure(version_of(0), 32'h0000_0000);
		send_word(32'h0000_0000, 32'h0000_0000);
		send_word(32'h0000_0000, 32'hFFFF_FFFF);
		send_word(32'hFFFF_FFFF, 32'h0000_0000);
		send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		configure(version_of(KEY_CANDIDATES - 1), 32'hFFFF_FFFF);
		send_word(32'hFFFF_FFFF, 32'hA5A5_5A5A);
		send_word(32'h0000_0000, 32'h5A5A_A5A5);
	endtask

	// A version byte no candidate produces: key zero, key_found low.
	task automatic test_missing_key();
		logic [7:0]   orphan;
		version_key_t probe;
		orphan = 8'h00;
		for (int v = 255; v >= 0; v--) begin
			probe = lookup_key(8'(v));
			if (!probe.found)
				orphan = 8'(v);
		end
		configure(orphan, 32'h0000_0040);
		send_word(32'h0000_0040, 32'h1234_5678);
		send_word(32'h0000_0000, 32'h8765_4321);
		send_word(32'hFFFF_FFFF, 32'h0F0F_F0F0);
	endtask

	// Pick positions whose keyed value has zero in its low five bits, so the
	// rotate passes it through.
	task automatic test_zero_rotate();
		logic [31:0] base;
		configure(version_of(0), 32'h0000_0123);
		for (int r = 0; r < 3; r++) begin
			base = $urandom & 32'hFFFF_FFE0;
			for (int k = 0; k < 32; k++) begin
				if (keyed_mix(base | 32'(k)) % 32 == 0) begin
					send_word(base | 32'(k), $urandom);
					break;
				end
			end
		end
	endtask

	// Positions below data start wrap around.
	task automatic test_position_wrap();
		configure(version_of(17), 32'h8000_0000);
		send_word(32'h7FFF_FFFF, $urandom);
		send_word(32'h0000_0000, $urandom);
		configure(version_of(101), 32'hFFFF_FFF0);
		send_word(32'h0000_0010, $urandom);
		send_word(32'hFFFF_FFEF, $urandom);
	endtask

	// Four idling phases, each with several register settings. Positions are
	// mostly near data start, as directory parsing reads them, some wrapped
	// below it, the rest anywhere.
	task automatic test_random_traffic();
		int unsigned src_pct[4];
		int unsigned sink_pct[4];
		logic [7:0]  version;
		logic [31:0] start;
		logic [31:0] pos;
		logic [31:0] word;
		src_pct = '{0, 64, 0, 14};
		sink_pct = '{0, 0, 64, 14};
		for (int phase = 0; phase < 4; phase++) begin
			for (int seg = 0; seg < 4; seg++) begin
				case (seg)
					0: begin
						version = phase[0] ? 8'hFF : 8'h00;
						start = phase[1] ? 32'hFFFF_FFFF : 32'h0000_0000;
					end
					1: begin
						version = version_of($urandom_range(0, KEY_CANDIDATES - 1));
						start = $urandom;
					end
					2: begin
						version = 8'($urandom);
						start = $urandom_range(0, 65535);
					end
					default: begin
						version = version_of($urandom_range(0, KEY_CANDIDATES - 1));
						start = $urandom;
					end
				endcase
				configure(version, start);
				// Switch idling only with the pipeline quiet.
				src_idle_pct = src_pct[phase];
				sink_stall_pct = sink_pct[phase];
				for (int n = 0; n < 75; n++) begin
					case ($urandom_range(0, 3))
						0: pos = shadow_start + $urandom_range(0, 4095);
						1: pos = shadow_start - $urandom_range(1, 256);
						2: pos = shadow_start + $urandom_range(0, 1 << 20);
						default: pos = $urandom;
					endcase
					case ($urandom_range(0, 15))
						0: word = 32'h0000_0000;
						1: word = 32'hFFFF_FFFF;
						default: word = $urandom;
					endcase
					send_word(pos, word);
				end
			end
		end
		src_idle_pct = 0;
		sink_stall_pct = 0;
	endtask

	initial begin
		mismatch_count = 0;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		word_position = '0;
		scrambled_word = '0;
		cfg_we = 1'b0;
		cfg_index = REG_VERSION_BYTE;
		cfg_data = '0;
		shadow_version = 8'h00;
		shadow_start = '0;
		shadow_key = lookup_key(8'h00);
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_field_extremes();
		test_missing_key();
		test_zero_rotate();
		test_position_wrap();
		test_random_traffic();

		drain_pipeline();
		if (mismatch_count == 0 && pending_offsets.size() == 0) begin
			$display("archive_offset_descrambler_core_test: clean");
		end else begin
			$display("archive_offset_descrambler_core_test: errors");
		end
		$finish;
	end

endmodule

// ===== archive_offset_descrambler_core.f =====
hw/rtl/aod_pkg.sv
hw/rtl/aod_front.sv
hw/rtl/aod_queue.sv
hw/rtl/aod_back.sv
hw/rtl/archive_offset_descrambler_core.sv
hw/rtl/aod_checker.sv
tb/archive_offset_descrambler_core_test.sv
